@@ rtl/lcgsb_pkg.sv @@
// Shared constants, types and functions for the LCG substitution-table byte scrambler.
// No dependencies; imported by lcg_sbox_byte_scrambler (lcgsb_ram does not use it).
`timescale 1ns / 1ps

package lcgsb_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int BYTE_W        = 8;
    localparam int SEED_W        = 32;
    localparam int PASSES_W      = 4;
    localparam int SWAP_CNT_W    = PASSES_W + TABLE_AW;
    localparam int CFG_IDX_W     = 2;
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_AW        = $clog2(OUT_DEPTH);

    localparam logic [SEED_W-1:0]   LCG_MULT           = 32'h0808_8405;
    localparam logic [SEED_W-1:0]   KEY_SEED_RESET     = 32'h0131_a9d3;
    localparam logic [SEED_W-1:0]   SHUFFLE_SEED_RESET = 32'h0132_9436;
    localparam logic [PASSES_W-1:0] PASSES_RESET       = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_SEED       = 2'd0,
        CFG_SHUFFLE_SEED   = 2'd1,
        CFG_SHUFFLE_PASSES = 2'd2
    } t_cfg_idx;

    typedef enum logic [8:0] {
        S_INIT   = 9'b0_0000_0001,
        S_DRAW_A = 9'b0_0000_0010,
        S_DRAW_B = 9'b0_0000_0100,
        S_RD_A   = 9'b0_0000_1000,
        S_RD_B   = 9'b0_0001_0000,
        S_WR_A   = 9'b0_0010_0000,
        S_WR_B   = 9'b0_0100_0000,
        S_INV    = 9'b0_1000_0000,
        S_READY  = 9'b1_0000_0000
    } t_state;

    function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] prod;
        prod = s * LCG_MULT;
        return prod + SEED_W'(1);
    endfunction

    function automatic logic [BYTE_W-1:0] top_byte(input logic [SEED_W-1:0] s);
        return s[SEED_W-1 -: BYTE_W];
    endfunction

endpackage

@@ rtl/lcgsb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for both substitution tables.
`timescale 1ns / 1ps

module lcgsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lcg_sbox_byte_scrambler.sv @@
// A request accepted on s_axis reads the table RAMs (registered read data) and its result
// is written into the output queue that feeds m_axis. Throughput: one byte per cycle once
// the tables are built, while the output queue has room; the forward and inverse tables
// live in two RAMs with one read and one write port each. Reset (synchronous, active low)
// and every register write start a table rebuild: identity fill, 256 x shuffle_passes swaps
// (equal draws redrawn), then the inverse; no request is taken meanwhile. Uses lcgsb_pkg, lcgsb_ram.
`timescale 1ns / 1ps

module lcg_sbox_byte_scrambler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lcgsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcgsb_pkg::SEED_W-1:0]       i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lcgsb_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] in_byte
    input  logic [1:0]                         s_axis_tuser,  // [0] mode, [1] restart
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lcgsb_pkg::BYTE_W-1:0]       m_axis_tdata   // [7:0] out_byte
);

    import lcgsb_pkg::*;

    t_state                r_state, n_state;
    logic [TABLE_AW:0]     r_cnt, n_cnt;
    logic [SWAP_CNT_W-1:0] r_swap, n_swap;
    logic [SWAP_CNT_W-1:0] swap_total;
    logic [SEED_W-1:0]     r_s, n_s, s_next;
    logic [BYTE_W-1:0]     r_a, n_a, r_b, n_b, r_fa, n_fa;
    logic                  r_inv_wv, n_inv_wv;
    logic [BYTE_W-1:0]     r_inv_idx, n_inv_idx;

    logic [SEED_W-1:0]     r_key_seed, r_shuffle_seed;
    logic [PASSES_W-1:0]   r_passes;
    logic [SEED_W-1:0]     r_ks;
    logic [BYTE_W-1:0]     r_key;
    logic                  r_mode;
    logic                  r_v1;

    logic                  fwd_we;
    logic [TABLE_AW-1:0]   fwd_wa, fwd_ra, inv_ra;
    logic [BYTE_W-1:0]     fwd_wd, fwd_rd, inv_rd;

    logic                  cfg_fire, s_fire, m_fire;
    logic [SEED_W-1:0]     ks_src, ks_new;
    logic [BYTE_W-1:0]     key;
    logic [BYTE_W-1:0]     result;

    logic [BYTE_W-1:0]     r_fifo [OUT_DEPTH];
    logic [OUT_AW-1:0]     r_wp, r_rp;
    logic [OUT_AW:0]       r_count;
    logic [OUT_AW:0]       pending;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign swap_total  = {r_passes, TABLE_AW'(0)};
    assign s_next      = lcg_next(r_s);

    // table build sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_swap    = r_swap;
        n_s       = r_s;
        n_a       = r_a;
        n_b       = r_b;
        n_fa      = r_fa;
        n_inv_wv  = 1'b0;
        n_inv_idx = r_inv_idx;
        fwd_we    = 1'b0;
        fwd_wa    = r_cnt[TABLE_AW-1:0];
        fwd_wd    = r_cnt[TABLE_AW-1:0];
        fwd_ra    = s_axis_tdata;
        unique case (r_state)
            S_INIT: begin
                fwd_we = 1'b1;
                n_s    = r_shuffle_seed;
                n_swap = '0;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt[TABLE_AW-1:0] == {TABLE_AW{1'b1}}) begin
                    n_cnt   = '0;
                    n_state = (swap_total == '0) ? S_INV : S_DRAW_A;
                end
            end
            S_DRAW_A: begin
                n_s     = s_next;
                n_a     = top_byte(s_next);
                n_state = S_DRAW_B;
            end
            S_DRAW_B: begin
                n_s = s_next;
                n_b = top_byte(s_next);
                if (top_byte(s_next) != r_a) begin
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                fwd_ra  = r_a;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                fwd_ra  = r_b;
                n_fa    = fwd_rd;
                n_state = S_WR_A;
            end
            S_WR_A: begin
                fwd_we  = 1'b1;
                fwd_wa  = r_a;
                fwd_wd  = fwd_rd;
                n_state = S_WR_B;
            end
            S_WR_B: begin
                fwd_we  = 1'b1;
                fwd_wa  = r_b;
                fwd_wd  = r_fa;
                n_swap  = r_swap + 1'b1;
                n_state = (n_swap == swap_total) ? S_INV : S_DRAW_A;
            end
            S_INV: begin
                fwd_ra    = r_cnt[TABLE_AW-1:0];
                n_inv_wv  = !r_cnt[TABLE_AW];
                n_inv_idx = r_cnt[TABLE_AW-1:0];
                if (!r_cnt[TABLE_AW]) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = S_READY;
                end
            end
            S_READY: begin
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (cfg_fire) begin
            n_state = S_INIT;
            n_cnt   = '0;
        end
    end

    // request path: keystream step, table reads, output queue
    assign ks_src  = s_axis_tuser[1] ? r_key_seed : r_ks;
    assign ks_new  = lcg_next(ks_src);
    assign key     = top_byte(ks_new);
    assign inv_ra  = s_axis_tdata ^ key;
    assign result  = r_mode ? inv_rd : (fwd_rd ^ r_key);

    assign pending       = r_count + {{OUT_AW{1'b0}}, r_v1};
    assign s_axis_tready = (r_state == S_READY) && (pending < (OUT_AW + 1)'(OUT_DEPTH));
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_fifo[r_rp];
    assign m_fire        = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_cnt          <= '0;
            r_swap         <= '0;
            r_inv_wv       <= 1'b0;
            r_key_seed     <= KEY_SEED_RESET;
            r_shuffle_seed <= SHUFFLE_SEED_RESET;
            r_passes       <= PASSES_RESET;
            r_ks           <= KEY_SEED_RESET;
            r_v1           <= 1'b0;
            r_wp           <= '0;
            r_rp           <= '0;
            r_count        <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_swap   <= n_swap;
            r_inv_wv <= n_inv_wv;
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_KEY_SEED:       r_key_seed     <= i_cfg_data;
                    CFG_SHUFFLE_SEED:   r_shuffle_seed <= i_cfg_data;
                    CFG_SHUFFLE_PASSES: r_passes       <= i_cfg_data[PASSES_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_fire) begin
                r_ks <= ks_new;
            end
            r_v1 <= s_fire;
            if (r_v1) begin
                r_wp <= r_wp + 1'b1;
            end
            if (m_fire) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + {{OUT_AW{1'b0}}, r_v1} - {{OUT_AW{1'b0}}, m_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s       <= n_s;
        r_a       <= n_a;
        r_b       <= n_b;
        r_fa      <= n_fa;
        r_inv_idx <= n_inv_idx;
        if (s_fire) begin
            r_key  <= key;
            r_mode <= s_axis_tuser[0];
        end
        if (r_v1) begin
            r_fifo[r_wp] <= result;
        end
    end

    lcgsb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (fwd_we),
        .i_waddr (fwd_wa),
        .i_wdata (fwd_wd),
        .i_raddr (fwd_ra),
        .o_rdata (fwd_rd)
    );

    lcgsb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (r_inv_wv),
        .i_waddr (fwd_rd),
        .i_wdata (r_inv_idx),
        .i_raddr (inv_ra),
        .o_rdata (inv_rd)
    );

endmodule
